@@ design/svang_pkg.sv @@
// shared types and constants for the signed vector angle core
// no dependencies; used by every module of the core
package svang_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int PROD_W      = 32;   // one coordinate product
    localparam int SUM_W       = 33;   // dot and cross products
    localparam int LEN_W       = 32;   // squared length of one vector
    localparam int LENPROD_W   = 64;   // product of both squared lengths
    localparam int THR_W       = 63;   // threshold register
    localparam int NORM_W      = 44;   // cordic x and y datapath
    localparam int NORM_EXP    = 40;   // normalized magnitude lies in [2^40, 2^41)
    localparam int ANG_W       = 28;   // q.24 angle accumulator
    localparam int OUT_W       = 16;
    localparam int RND_SHIFT   = 11;
    localparam int TABLE_LEN   = 24;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353590;
    localparam logic signed [ANG_W-1:0] RND_HALF    = 28'sd1024;
    localparam logic signed [OUT_W-1:0] OUT_PI      = 16'sd25736;
    localparam logic [THR_W-1:0]        THR_RESET   = 63'd43;

    // register select bit of paddr (registers are 8 bytes apart)
    localparam logic REG_MIN_LEN_SQ = 1'b0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] angle;
        logic                    degenerate;
    } out_beat_t;

    // sideband that travels with every pipeline stage
    typedef struct packed {
        logic valid;
        logic degenerate;
        logic crs_zero;
        logic dot_neg;
    } ctl_t;

    // arctangent of 2^-i in q.24
    function automatic logic signed [ANG_W-1:0] atan_q24(input int idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            0:  val = 28'sd13176795;
            1:  val = 28'sd7778716;
            2:  val = 28'sd4110060;
            3:  val = 28'sd2086331;
            4:  val = 28'sd1047214;
            5:  val = 28'sd524117;
            6:  val = 28'sd262123;
            7:  val = 28'sd131069;
            8:  val = 28'sd65536;
            9:  val = 28'sd32768;
            10: val = 28'sd16384;
            11: val = 28'sd8192;
            12: val = 28'sd4096;
            13: val = 28'sd2048;
            14: val = 28'sd1024;
            15: val = 28'sd512;
            16: val = 28'sd256;
            17: val = 28'sd128;
            18: val = 28'sd64;
            19: val = 28'sd32;
            20: val = 28'sd16;
            21: val = 28'sd8;
            22: val = 28'sd4;
            23: val = 28'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ design/svang_front.sv @@
// front end: coordinate products, dot/cross sums, length product, quadrant fold
// depends on svang_pkg
module svang_front
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  svang_pkg::in_beat_t                       in_beat,
    output svang_pkg::ctl_t                           ctl_out,
    output logic signed [svang_pkg::SUM_W-1:0]        x_out,
    output logic signed [svang_pkg::SUM_W-1:0]        y_out,
    output logic signed [svang_pkg::ANG_W-1:0]        z_out,
    output logic [svang_pkg::LENPROD_W-1:0]           lenprod_out
);

    localparam int PW = svang_pkg::PROD_W;
    localparam int SW = svang_pkg::SUM_W;
    localparam int LW = svang_pkg::LEN_W;

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [PW-1:0] pxx_next, pyy_next, pxy_next, pyx_next;
    logic [PW-2:0]        sa1_reg, sa2_reg, sb1_reg, sb2_reg;
    logic [PW-2:0]        sa1_next, sa2_next, sb1_next, sb2_next;

    // stage 2: sums
    logic                 v2_reg;
    logic signed [SW-1:0] dot_reg, crs_reg, dot_next, crs_next;
    logic [LW-1:0]        lena_reg, lenb_reg, lena_next, lenb_next;

    // stage 3: length product and quadrant fold
    svang_pkg::ctl_t                     ctl3_reg, ctl3_next;
    logic signed [SW-1:0]                x3_reg, y3_reg, x3_next, y3_next;
    logic signed [svang_pkg::ANG_W-1:0]  z3_reg, z3_next;
    logic [svang_pkg::LENPROD_W-1:0]     lp_reg, lp_next;

    always_comb
    begin
        logic signed [PW-1:0] ax, ay, bx, by;
        logic signed [PW-1:0] sqa1, sqa2, sqb1, sqb2;
        ax = PW'(in_beat.first_x);
        ay = PW'(in_beat.first_y);
        bx = PW'(in_beat.second_x);
        by = PW'(in_beat.second_y);
        pxx_next = ax * bx;
        pyy_next = ay * by;
        pxy_next = ax * by;
        pyx_next = ay * bx;
        sqa1 = ax * ax;
        sqa2 = ay * ay;
        sqb1 = bx * bx;
        sqb2 = by * by;
        sa1_next = sqa1[PW-2:0];
        sa2_next = sqa2[PW-2:0];
        sb1_next = sqb1[PW-2:0];
        sb2_next = sqb2[PW-2:0];
    end

    always_comb
    begin
        dot_next  = SW'(pxx_reg) + SW'(pyy_reg);
        crs_next  = SW'(pxy_reg) - SW'(pyx_reg);
        lena_next = LW'(sa1_reg) + LW'(sa2_reg);
        lenb_next = LW'(sb1_reg) + LW'(sb2_reg);
    end

    always_comb
    begin
        ctl3_next            = '0;
        ctl3_next.valid      = v2_reg;
        ctl3_next.crs_zero   = (crs_reg == '0);
        ctl3_next.dot_neg    = dot_reg[SW-1];
        lp_next              = svang_pkg::LENPROD_W'(lena_reg)
                             * svang_pkg::LENPROD_W'(lenb_reg);
        x3_next              = dot_reg;
        y3_next              = crs_reg;
        z3_next              = '0;
        // fold the left half plane into the right one
        if (dot_reg[SW-1])
        begin
            if (!crs_reg[SW-1])
            begin
                x3_next = crs_reg;
                y3_next = -dot_reg;
                z3_next = svang_pkg::ANG_HALF_PI;
            end
            else
            begin
                x3_next = -crs_reg;
                y3_next = dot_reg;
                z3_next = -svang_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pxx_reg  <= pxx_next;
        pyy_reg  <= pyy_next;
        pxy_reg  <= pxy_next;
        pyx_reg  <= pyx_next;
        sa1_reg  <= sa1_next;
        sa2_reg  <= sa2_next;
        sb1_reg  <= sb1_next;
        sb2_reg  <= sb2_next;
        dot_reg  <= dot_next;
        crs_reg  <= crs_next;
        lena_reg <= lena_next;
        lenb_reg <= lenb_next;
        x3_reg   <= x3_next;
        y3_reg   <= y3_next;
        z3_reg   <= z3_next;
        lp_reg   <= lp_next;
    end

    assign ctl_out     = ctl3_reg;
    assign x_out       = x3_reg;
    assign y_out       = y3_reg;
    assign z_out       = z3_reg;
    assign lenprod_out = lp_reg;

endmodule

@@ design/svang_norm.sv @@
// normalizer: two-stage binary left shift of x/y into [2^40, 2^41), threshold test
// depends on svang_pkg
module svang_norm
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  svang_pkg::ctl_t                       ctl_in,
    input  logic signed [svang_pkg::SUM_W-1:0]    x_in,
    input  logic signed [svang_pkg::SUM_W-1:0]    y_in,
    input  logic signed [svang_pkg::ANG_W-1:0]    z_in,
    input  logic [svang_pkg::LENPROD_W-1:0]       lenprod_in,
    input  logic [svang_pkg::THR_W-1:0]           threshold,
    output svang_pkg::ctl_t                       ctl_out,
    output logic signed [svang_pkg::NORM_W-1:0]   x_out,
    output logic signed [svang_pkg::NORM_W-1:0]   y_out,
    output logic signed [svang_pkg::ANG_W-1:0]    z_out
);

    localparam int NW = svang_pkg::NORM_W;
    localparam int NE = svang_pkg::NORM_EXP;

    svang_pkg::ctl_t                     ctl1_reg, ctl1_next, ctl2_reg;
    logic signed [NW-1:0]                x1_reg, y1_reg, x1_next, y1_next;
    logic [NW-1:0]                       m1_reg, m1_next;
    logic signed [svang_pkg::ANG_W-1:0]  z1_reg, z2_reg;
    logic signed [NW-1:0]                x2_reg, y2_reg, x2_next, y2_next;

    // first half: shifts of 32, 16, 8
    always_comb
    begin
        logic signed [NW-1:0] xs, ys;
        logic [NW-1:0]        ax, ay, m;
        xs = NW'(x_in);
        ys = NW'(y_in);
        ax = xs[NW-1] ? NW'(-xs) : NW'(xs);
        ay = ys[NW-1] ? NW'(-ys) : NW'(ys);
        m  = ax | ay;
        for (int k = 0; k < 3; k++)
        begin
            if ((m >> (NE + 1 - (32 >> k))) == '0)
            begin
                xs = xs <<< (32 >> k);
                ys = ys <<< (32 >> k);
                m  = m << (32 >> k);
            end
        end
        x1_next = xs;
        y1_next = ys;
        m1_next = m;
        ctl1_next = ctl_in;
        ctl1_next.degenerate = (lenprod_in < svang_pkg::LENPROD_W'(threshold));
    end

    // second half: shifts of 4, 2, 1
    always_comb
    begin
        logic signed [NW-1:0] xs, ys;
        logic [NW-1:0]        m;
        xs = x1_reg;
        ys = y1_reg;
        m  = m1_reg;
        for (int k = 3; k < 6; k++)
        begin
            if ((m >> (NE + 1 - (32 >> k))) == '0)
            begin
                xs = xs <<< (32 >> k);
                ys = ys <<< (32 >> k);
                m  = m << (32 >> k);
            end
        end
        x2_next = xs;
        y2_next = ys;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        m1_reg <= m1_next;
        z1_reg <= z_in;
        x2_reg <= x2_next;
        y2_reg <= y2_next;
        z2_reg <= z1_reg;
    end

    assign ctl_out = ctl2_reg;
    assign x_out   = x2_reg;
    assign y_out   = y2_reg;
    assign z_out   = z2_reg;

endmodule

@@ design/svang_cordic_stage.sv @@
// one registered cordic vectoring micro-rotation
// depends on svang_pkg
module svang_cordic_stage
#(
    parameter int STEP = 0
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  svang_pkg::ctl_t                       ctl_in,
    input  logic signed [svang_pkg::NORM_W-1:0]   x_in,
    input  logic signed [svang_pkg::NORM_W-1:0]   y_in,
    input  logic signed [svang_pkg::ANG_W-1:0]    z_in,
    output svang_pkg::ctl_t                       ctl_out,
    output logic signed [svang_pkg::NORM_W-1:0]   x_out,
    output logic signed [svang_pkg::NORM_W-1:0]   y_out,
    output logic signed [svang_pkg::ANG_W-1:0]    z_out
);

    localparam logic signed [svang_pkg::ANG_W-1:0] ATAN = svang_pkg::atan_q24(STEP);

    svang_pkg::ctl_t                        ctl_reg;
    logic signed [svang_pkg::NORM_W-1:0]    x_reg, y_reg, x_next, y_next;
    logic signed [svang_pkg::ANG_W-1:0]     z_reg, z_next;

    always_comb
    begin
        if (!y_in[svang_pkg::NORM_W-1])
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

endmodule

@@ design/signed_vector_angle_core.sv @@
// signed_vector_angle_core: signed angle from a first 2-D vector to a second
// depends on svang_pkg, svang_front, svang_norm, svang_cordic_stage
//
// usage
//   input beat: operands (two q8.8 vectors) is taken at each clock edge where
//   start is high and busy is low; busy is always low, so one beat per cycle
//   output beat: result (angle in q3.13 radians, degenerate flag) is valid for
//   exactly one cycle while done is high; the receiver cannot stall the core
//   pipeline from accept to done: 3 product/sum stages, 2 normalize stages,
//   one stage per cordic micro-rotation and one rounding stage
//   throughput: one beat per cycle, the whole datapath is a free-running
//   pipeline with a valid bit per stage
//   config: min_len_sq_product at paddr 0 over the apb port, 64-bit data;
//   write only while the pipeline is empty
//   reset: rst_n clears every valid bit and loads the threshold with 43;
//   beats in flight are dropped
module signed_vector_angle_core
#(
    parameter int CORDIC_STEPS = 14
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  svang_pkg::in_beat_t               operands,
    output logic                              done,
    output svang_pkg::out_beat_t              result,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [svang_pkg::PADDR_W-1:0]     paddr,
    input  logic [svang_pkg::PDATA_W-1:0]     pwdata,
    output logic [svang_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    localparam int NW = svang_pkg::NORM_W;
    localparam int AW = svang_pkg::ANG_W;
    localparam int SW = svang_pkg::SUM_W;
    localparam int OW = svang_pkg::OUT_W;
    localparam int RW = AW - svang_pkg::RND_SHIFT;

    // threshold register
    logic [svang_pkg::THR_W-1:0] thr_reg;
    logic                        cfg_wr;

    // front end outputs
    svang_pkg::ctl_t             fe_ctl;
    logic signed [SW-1:0]        fe_x, fe_y;
    logic signed [AW-1:0]        fe_z;
    logic [svang_pkg::LENPROD_W-1:0] fe_lenprod;

    // cordic chain, entry 0 is the normalizer output
    svang_pkg::ctl_t             ch_ctl [CORDIC_STEPS+1];
    logic signed [NW-1:0]        ch_x   [CORDIC_STEPS+1];
    logic signed [NW-1:0]        ch_y   [CORDIC_STEPS+1];
    logic signed [AW-1:0]        ch_z   [CORDIC_STEPS+1];

    // output stage
    logic                        done_reg;
    svang_pkg::out_beat_t        res_reg, res_next;

    // the pipeline never stalls, so a beat is taken every cycle
    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[svang_pkg::PADDR_W-1] == svang_pkg::REG_MIN_LEN_SQ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= svang_pkg::THR_RESET;
        else if (cfg_wr)
            thr_reg <= pwdata[svang_pkg::THR_W-1:0];
    end

    // reads of any other address return zero
    assign prdata = (paddr[svang_pkg::PADDR_W-1] == svang_pkg::REG_MIN_LEN_SQ)
                  ? svang_pkg::PDATA_W'(thr_reg) : '0;

    svang_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .in_beat     (operands),
        .ctl_out     (fe_ctl),
        .x_out       (fe_x),
        .y_out       (fe_y),
        .z_out       (fe_z),
        .lenprod_out (fe_lenprod)
    );

    svang_norm u_norm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (fe_ctl),
        .x_in       (fe_x),
        .y_in       (fe_y),
        .z_in       (fe_z),
        .lenprod_in (fe_lenprod),
        .threshold  (thr_reg),
        .ctl_out    (ch_ctl[0]),
        .x_out      (ch_x[0]),
        .y_out      (ch_y[0]),
        .z_out      (ch_z[0])
    );

    // one registered micro-rotation per step
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        svang_cordic_stage #(.STEP(i)) u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ch_ctl[i]),
            .x_in    (ch_x[i]),
            .y_in    (ch_y[i]),
            .z_in    (ch_z[i]),
            .ctl_out (ch_ctl[i+1]),
            .x_out   (ch_x[i+1]),
            .y_out   (ch_y[i+1]),
            .z_out   (ch_z[i+1])
        );
    end

    // rounding to q3.13 with saturation, then the special cases
    always_comb
    begin
        logic signed [AW-1:0] zr;
        logic signed [RW-1:0] rnd;
        svang_pkg::ctl_t      c;
        c   = ch_ctl[CORDIC_STEPS];
        zr  = ch_z[CORDIC_STEPS] + svang_pkg::RND_HALF;
        rnd = zr[AW-1:svang_pkg::RND_SHIFT];
        res_next.degenerate = 1'b0;
        priority if (c.degenerate)
        begin
            res_next.angle      = '0;
            res_next.degenerate = 1'b1;
        end
        else if (c.crs_zero)
        begin
            // parallel gives zero, opposite gives plus pi
            res_next.angle = c.dot_neg ? svang_pkg::OUT_PI : '0;
        end
        else if (rnd > RW'(svang_pkg::OUT_PI))
            res_next.angle = svang_pkg::OUT_PI;
        else if (rnd < RW'(-svang_pkg::OUT_PI))
            res_next.angle = -svang_pkg::OUT_PI;
        else
            res_next.angle = rnd[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ch_ctl[CORDIC_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ verif/angle_check_pkg.sv @@
`timescale 1ns / 1ps
// prediction and checking of angle results for the signed vector angle core
// depends on svang_pkg for the beat types and the threshold width
package angle_check_pkg;

    import svang_pkg::*;

    localparam longint PI_Q13       = 25736;
    localparam longint HALF_PI_Q24  = 26353590;
    localparam longint NORM_FLOOR   = longint'(1) << 40;
    localparam longint ROUND_HALF   = 1024;
    localparam int     ROUND_SHIFT  = 11;
    localparam int     ROT_TABLE_LEN = 24;
    localparam logic [THR_W-1:0] MIN_LEN_SQ_RESET = 63'd43;

    class angle_scoreboard;

        logic [THR_W-1:0] min_len_sq;
        out_beat_t        pending_angles[$];
        int unsigned      mismatches;
        int               cordic_steps;
        longint           rot_angle[ROT_TABLE_LEN];

        function new(int steps);
            cordic_steps = steps;
            min_len_sq   = MIN_LEN_SQ_RESET;
            mismatches   = 0;
            // atan(2^-i) in q.24
            rot_angle = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        endfunction

        function out_beat_t predict_angle(in_beat_t pair);
            longint      ax, ay, bx, by, dot, crs;
            longint      x, y, z, m, t, xs, ys, ang;
            logic [63:0] mag_sq_prod;
            out_beat_t   res;
            int          i;
            ax = longint'($signed(pair.first_x));
            ay = longint'($signed(pair.first_y));
            bx = longint'($signed(pair.second_x));
            by = longint'($signed(pair.second_y));
            res.angle      = '0;
            res.degenerate = 1'b0;
            mag_sq_prod = 64'((ax * ax + ay * ay) * (bx * bx + by * by));
            if (mag_sq_prod < {1'b0, min_len_sq})
            begin
                res.degenerate = 1'b1;
                return res;
            end
            dot = ax * bx + ay * by;
            crs = ax * by - ay * bx;
            if (crs == 0)
            begin
                ang = (dot < 0) ? PI_Q13 : 0;
            end
            else
            begin
                x = dot;
                y = crs;
                z = 0;
                // fold the left half plane onto the right one
                if (x < 0)
                begin
                    if (y >= 0)
                    begin
                        t = x; x = y; y = -t; z = HALF_PI_Q24;
                    end
                    else
                    begin
                        t = x; x = -y; y = t; z = -HALF_PI_Q24;
                    end
                end
                m = (x < 0 ? -x : x) | (y < 0 ? -y : y);
                while (m != 0 && m < NORM_FLOOR)
                begin
                    x = x * 2; y = y * 2; m = m * 2;
                end
                for (i = 0; i < cordic_steps && i < ROT_TABLE_LEN; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys; y = y - xs; z = z + rot_angle[i];
                    end
                    else
                    begin
                        x = x - ys; y = y + xs; z = z - rot_angle[i];
                    end
                end
                ang = (z + ROUND_HALF) >>> ROUND_SHIFT;
                if (ang > PI_Q13)
                    ang = PI_Q13;
                if (ang < -PI_Q13)
                    ang = -PI_Q13;
            end
            res.angle = 16'(ang);
            return res;
        endfunction

        function void note_pair(in_beat_t pair);
            pending_angles.push_back(predict_angle(pair));
        endfunction

        function void check_angle(out_beat_t got);
            out_beat_t want;
            if (pending_angles.size() == 0)
            begin
                $display("%0t unexpected result: angle %0d degenerate %0b",
                         $time, $signed(got.angle), got.degenerate);
                mismatches++;
                return;
            end
            want = pending_angles.pop_front();
            if (got.angle !== want.angle)
            begin
                $display("%0t angle mismatch: expected %0d actual %0d",
                         $time, $signed(want.angle), $signed(got.angle));
                mismatches++;
            end
            if (got.degenerate !== want.degenerate)
            begin
                $display("%0t degenerate mismatch: expected %0b actual %0b",
                         $time, want.degenerate, got.degenerate);
                mismatches++;
            end
        endfunction

    endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// top-level testbench for signed_vector_angle_core: drives vector pairs and
// the threshold register, depends on svang_pkg and angle_check_pkg
module tb;

    import svang_pkg::*;
    import angle_check_pkg::*;

    localparam int CORDIC_STEPS  = 14;
    // accept to done: front end, normalizer, cordic steps and rounding stage
    localparam int PIPE_LATENCY  = CORDIC_STEPS + 6;
    localparam int PHASES        = 8;
    localparam int PHASE_PAIRS   = 200;
    localparam logic [PADDR_W-1:0] MIN_LEN_SQ_ADDR = '0;
    localparam logic [PDATA_W-1:0] THR_MAX         = 64'h4000_0000_0000_0000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_beat_t            operands;
    logic                done;
    out_beat_t           result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    angle_scoreboard     sb;
    // set during one phase so the core sees a long unbroken stream of beats
    bit                  sender_steady;

    signed_vector_angle_core #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: the core cannot be held off, so every done cycle is a beat;
    // reading right after the edge sees the values that the edge sampled
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_angle(result);
    end

    function automatic in_beat_t pair_of(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] bx,
                                         input logic signed [15:0] by);
        in_beat_t p;
        p.first_x  = ax;
        p.first_y  = ay;
        p.second_x = bx;
        p.second_y = by;
        return p;
    endfunction

    // mix of full-range, narrow, tiny and corner coordinates
    function automatic logic signed [15:0] random_coord();
        logic signed [15:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 4))
            0: return raw >>> $urandom_range(0, 15);
            1: return 16'($signed($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shffff;
                endcase
            end
            default: return raw;
        endcase
    endfunction

    // second vector is sometimes tied to the first so that parallel, opposite
    // and perpendicular cases show up often
    function automatic in_beat_t random_pair();
        in_beat_t p;
        p.first_x = random_coord();
        p.first_y = random_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                p.second_x = p.first_x;
                p.second_y = p.first_y;
            end
            1:
            begin
                p.second_x = -p.first_x;
                p.second_y = -p.first_y;
            end
            2:
            begin
                p.second_x = p.first_x <<< 1;
                p.second_y = p.first_y <<< 1;
            end
            3:
            begin
                p.second_x = -p.first_y;
                p.second_y = p.first_x;
            end
            default:
            begin
                p.second_x = random_coord();
                p.second_y = random_coord();
            end
        endcase
        return p;
    endfunction

    // threshold spread over the whole range of length products
    function automatic logic [PDATA_W-1:0] random_threshold();
        int unsigned        k;
        logic [PDATA_W-1:0] low;
        k   = $urandom_range(0, 61);
        low = {$urandom, $urandom};
        return (64'd1 << k) | (low & ((64'd1 << k) - 64'd1));
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_pair(input in_beat_t pair);
        while (!sender_steady && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        operands <= pair;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_pair(pair);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
    endtask

    // apb write of the threshold, then a back-to-back read to check it
    task automatic set_min_len_sq(input logic [PDATA_W-1:0] value);
        drain_pipeline();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_LEN_SQ_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.min_len_sq = value[THR_W-1:0];
        // read setup follows straight on, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[THR_W-1:0] !== value[THR_W-1:0])
        begin
            $display("%0t threshold readback mismatch: expected %0d actual %0d",
                     $time, value[THR_W-1:0], prdata[THR_W-1:0]);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int n;
        sb            = new(CORDIC_STEPS);
        sender_steady = 1'b0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        operands <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        // threshold still at its reset value
        send_pair(pair_of(0, 0, 0, 0));                  // zero vectors, degenerate
        send_pair(pair_of(1, 0, 1, 0));                  // tiny product, degenerate
        send_pair(pair_of(0, 1, 0, 6));                  // just under the threshold
        send_pair(pair_of(0, 1, 0, 7));                  // just over, parallel
        send_pair(pair_of(7, 0, 0, 7));                  // plus half pi
        send_pair(pair_of(7, 0, 0, -7));                 // minus half pi
        send_pair(pair_of(256, 0, -256, 0));             // opposite on x
        send_pair(pair_of(0, 256, 0, -256));             // opposite on y
        send_pair(pair_of(256, 256, 512, 512));          // parallel
        send_pair(pair_of(32767, 32767, -32768, -32768));
        send_pair(pair_of(-32768, -32768, -32768, -32768));
        send_pair(pair_of(256, 0, -256, 1));             // just short of plus pi
        send_pair(pair_of(256, 0, -256, -1));            // just short of minus pi
        send_pair(pair_of(32767, 0, -32768, 1));         // rounds to the range edge
        send_pair(pair_of(32767, 0, -32768, -1));
        send_pair(pair_of(-32768, 32767, 32767, -32768));
        send_pair(pair_of(100, -37, -45, 200));

        // zero threshold: zero vectors are no longer degenerate
        set_min_len_sq('0);
        send_pair(pair_of(0, 0, 0, 0));
        send_pair(pair_of(0, 0, 5, 3));
        send_pair(pair_of(1, 0, -1, 0));
        send_pair(pair_of(1, 0, 0, -1));

        // largest threshold: only the largest product gets through
        set_min_len_sq(THR_MAX);
        send_pair(pair_of(-32768, -32768, -32768, -32768));
        send_pair(pair_of(32767, -32768, -32768, -32768));

        // threshold equal to a reachable product
        set_min_len_sq(64'd2401);
        send_pair(pair_of(7, 0, 0, 7));
        send_pair(pair_of(7, 0, 0, -6));

        // random phases, each under its own threshold; every write drains first
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_min_len_sq(64'(MIN_LEN_SQ_RESET));
                2: set_min_len_sq('0);
                4: set_min_len_sq(THR_MAX);
                default: set_min_len_sq(random_threshold());
            endcase
            sender_steady = (phase == 3);
            for (n = 0; n < PHASE_PAIRS; n++)
                send_pair(random_pair());
        end
        sender_steady = 1'b0;

        // let anything stray fall out of the pipeline before judging
        drain_pipeline();
        repeat (PIPE_LATENCY + 10)
            @(posedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
